// ===== hdl/mf3_pkg.sv =====
package mf3_pkg;

  // Pixel width is fixed by the stream's pixel field.
  localparam int PIXEL_BITS = 8;

  // Largest frame height that the row counter supports.
  localparam int ROW_LIMIT = 4096;

  // Widths of the configuration registers and the position fields.
  localparam int COLS_REG_BITS = 12;
  localparam int ROWS_REG_BITS = 13;
  localparam int ROW_BITS      = 12;
  localparam int COL_BITS      = 11;

  // Configuration write port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_COLS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_ROWS = 2'd1;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // One window column, sorted from the smallest to the largest value.
  typedef struct packed {
    pix_t hi;
    pix_t md;
    pix_t lo;
  } col_t;

  // Bookkeeping that travels down the pipeline beside each request.
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } tag_t;

  // One filtered result.
  typedef struct packed {
    logic                last;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    pix_t                median;
  } res_t;

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    pix_t lo;
    pix_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end else begin
      return c;
    end
  endfunction

endpackage

// ===== hdl/mf3_sort3.sv =====
// Sorts the three pixels of one incoming window column.
module mf3_sort3 (
  input  mf3_pkg::pix_t top_i,
  input  mf3_pkg::pix_t mid_i,
  input  mf3_pkg::pix_t bot_i,
  output mf3_pkg::col_t col_o
);

  always_comb begin
    col_o.lo = mf3_pkg::min3(top_i, mid_i, bot_i);
    col_o.md = mf3_pkg::med3(top_i, mid_i, bot_i);
    col_o.hi = mf3_pkg::max3(top_i, mid_i, bot_i);
  end

endmodule

// ===== hdl/mf3_col_cell.sv =====
// One column of the sliding window. On each shift it takes the column of
// its left neighbor and hands its own column on to the right.
module mf3_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  mf3_pkg::col_t col_i,
  output mf3_pkg::col_t col_o
);

  mf3_pkg::col_t col_q;
  mf3_pkg::col_t col_d;

  always_comb begin
    col_d = shift_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hdl/median_filter_3x3.sv =====
// 3x3 median filter, one pixel accepted per clock when the output keeps up.
// A result reaches m_axis via the stage-1, window, stage-3 and output registers.
// Throughput: one pixel per cycle, set by the single-port-per-side line stores
// and the three-stage window and merge pipeline; a one-entry skid keeps input open.
// Reset (rst_ni low, asynchronous): counters, window cells and valids clear at once;
// line stores are not cleared and need no clearing pass.
module median_filter_3x3 #(
  parameter int MAX_COLS = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input pixel stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] pixel_in
  input  logic                                 s_axis_tuser,  // [0] frame_start
  // Filtered result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] median_out, [19:8] center_row, [30:20] center_col, [31] zero
  output logic [31:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast,  // frame_last
  // Configuration write port.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  // Address width of the line stores, and a counter width that holds
  // both MAX_COLS and the largest image_cols setting.
  localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNTW = $clog2(MAX_COLS + 1);
  localparam int CW   = (CNTW > mf3_pkg::COLS_REG_BITS) ? CNTW : mf3_pkg::COLS_REG_BITS;
  localparam int RW   = mf3_pkg::ROWS_REG_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers. The port is always ready; writes to an index
  // beyond the register list are dropped.
  // ---------------------------------------------------------------------
  logic [mf3_pkg::COLS_REG_BITS-1:0] img_cols_q, img_cols_d;
  logic [mf3_pkg::ROWS_REG_BITS-1:0] img_rows_q, img_rows_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    img_cols_d = img_cols_q;
    img_rows_d = img_rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mf3_pkg::CFG_IMAGE_COLS: img_cols_d = cfg_data_i[mf3_pkg::COLS_REG_BITS-1:0];
        mf3_pkg::CFG_IMAGE_ROWS: img_rows_d = cfg_data_i[mf3_pkg::ROWS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use, clamped to what the line stores and row counter hold.
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;

  always_comb begin
    cols_eff = CW'(img_cols_q);
    if (cols_eff < CW'(3)) begin
      cols_eff = CW'(3);
    end else if (cols_eff > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end
    rows_eff = img_rows_q;
    if (rows_eff < RW'(3)) begin
      rows_eff = RW'(3);
    end else if (rows_eff > RW'(mf3_pkg::ROW_LIMIT)) begin
      rows_eff = RW'(mf3_pkg::ROW_LIMIT);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Every stage moves together whenever the skid entry
  // is free, so the input ready comes straight from a register.
  // ---------------------------------------------------------------------
  logic pipe_en;
  logic accept;
  logic skid_v_q, skid_v_d;

  assign pipe_en       = !skid_v_q;
  assign s_axis_tready = pipe_en;
  assign accept        = s_axis_tvalid && pipe_en;

  // ---------------------------------------------------------------------
  // Position counters. A frame start forces the pixel to (0,0). The
  // position is wrapped before use in case the size shrank since the last
  // pixel, and again after stepping to the next column.
  // ---------------------------------------------------------------------
  logic [AW-1:0]                col_q, col_d;
  logic [mf3_pkg::ROW_BITS-1:0] row_q, row_d;
  logic [CW-1:0]                cur_col, nxt_col, col_m1;
  logic [RW-1:0]                cur_row, nxt_row, row_m1;
  mf3_pkg::tag_t                tag0;

  always_comb begin
    cur_col = s_axis_tuser ? '0 : CW'(col_q);
    cur_row = s_axis_tuser ? '0 : RW'(row_q);
    if (cur_col >= cols_eff) begin
      cur_col = '0;
      cur_row = cur_row + RW'(1);
    end
    if (cur_row >= rows_eff) begin
      cur_row = '0;
    end

    nxt_col = cur_col + CW'(1);
    nxt_row = cur_row;
    if (nxt_col >= cols_eff) begin
      nxt_col = '0;
      nxt_row = nxt_row + RW'(1);
    end
    if (nxt_row >= rows_eff) begin
      nxt_row = '0;
    end

    col_d = accept ? nxt_col[AW-1:0] : col_q;
    row_d = accept ? nxt_row[mf3_pkg::ROW_BITS-1:0] : row_q;

    // Results exist only for centers off the frame border.
    col_m1    = cur_col - CW'(1);
    row_m1    = cur_row - RW'(1);
    tag0.emit = (cur_row >= RW'(2)) && (cur_col >= CW'(2));
    tag0.last = (cur_row == rows_eff - RW'(1)) && (cur_col == cols_eff - CW'(1));
    tag0.row  = row_m1[mf3_pkg::ROW_BITS-1:0];
    tag0.col  = col_m1[mf3_pkg::COL_BITS-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read. The upper store holds the row two above,
  // the lower store the row above. Each pixel's column is read as the
  // pixel is accepted and rewritten as it leaves this stage.
  // ---------------------------------------------------------------------
  logic                v1_q;
  mf3_pkg::tag_t       tag1_q;
  mf3_pkg::pix_t       pix1_q;
  logic [AW-1:0]       addr1_q;
  mf3_pkg::pix_t       up_rd_q, lo_rd_q;
  logic                fwd_hit_q;
  mf3_pkg::pix_t       fwd_top_q, fwd_mid_q;
  mf3_pkg::pix_t       top1, mid1;
  logic                wr_en;
  logic [AW-1:0]       rd_addr;
  logic                fwd_hit;

  mf3_pkg::pix_t line_upper [MAX_COLS];
  mf3_pkg::pix_t line_lower [MAX_COLS];

  assign rd_addr = cur_col[AW-1:0];
  assign wr_en   = pipe_en && v1_q;

  // The pixel still in stage 1 writes its column at the same edge the new
  // pixel reads, so a read of that same column takes the write data.
  assign fwd_hit = v1_q && (addr1_q == rd_addr);
  assign top1    = fwd_hit_q ? fwd_top_q : up_rd_q;
  assign mid1    = fwd_hit_q ? fwd_mid_q : lo_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_upper[addr1_q] <= mid1;
      line_lower[addr1_q] <= pix1_q;
    end
    if (accept) begin
      up_rd_q <= line_upper[rd_addr];
      lo_rd_q <= line_lower[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag1_q    <= tag0;
      pix1_q    <= s_axis_tdata;
      addr1_q   <= rd_addr;
      fwd_hit_q <= fwd_hit;
      fwd_top_q <= mid1;
      fwd_mid_q <= pix1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the window. The new column is sorted and shifted into a row
  // of three column cells; after the shift the cells hold columns c, c-1
  // and c-2 of the request now in stage 2.
  // ---------------------------------------------------------------------
  mf3_pkg::col_t new_col, cell0, cell1, cell2;
  logic          v2_q;
  mf3_pkg::tag_t tag2_q;

  mf3_sort3 u_sort3 (
    .top_i (top1),
    .mid_i (mid1),
    .bot_i (pix1_q),
    .col_o (new_col)
  );

  mf3_col_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (wr_en),
    .col_i   (new_col),
    .col_o   (cell0)
  );

  mf3_col_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (wr_en),
    .col_i   (cell0),
    .col_o   (cell1)
  );

  mf3_col_cell u_cell2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (wr_en),
    .col_i   (cell1),
    .col_o   (cell2)
  );

  // ---------------------------------------------------------------------
  // Stage 3: with every column sorted, the median of nine is the median of
  // the largest low, the middle of the middles and the smallest high.
  // ---------------------------------------------------------------------
  logic          v3_q;
  mf3_pkg::tag_t tag3_q;
  mf3_pkg::pix_t lo_max_q, md_med_q, hi_min_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag2_q <= tag1_q;
    end
    if (pipe_en) begin
      tag3_q   <= tag2_q;
      lo_max_q <= mf3_pkg::max3(cell0.lo, cell1.lo, cell2.lo);
      md_med_q <= mf3_pkg::med3(cell0.md, cell1.md, cell2.md);
      hi_min_q <= mf3_pkg::min3(cell0.hi, cell1.hi, cell2.hi);
    end
  end

  // ---------------------------------------------------------------------
  // Output register with a one-entry skid behind it.
  // ---------------------------------------------------------------------
  logic          res_v;
  mf3_pkg::res_t res;
  logic          out_v_q, out_v_d;
  mf3_pkg::res_t out_q, out_d;
  mf3_pkg::res_t skid_q, skid_d;

  always_comb begin
    res_v      = v3_q && tag3_q.emit;
    res.median = mf3_pkg::med3(lo_max_q, md_med_q, hi_min_q);
    res.row    = tag3_q.row;
    res.col    = tag3_q.col;
    res.last   = tag3_q.last;

    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pipe_en) begin
      if (out_v_q && !m_axis_tready) begin
        if (res_v) begin
          skid_v_d = 1'b1;
          skid_d   = res;
        end
      end else begin
        out_v_d = res_v;
        out_d   = res;
      end
    end else if (m_axis_tready) begin
      out_v_d  = 1'b1;
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_cols_q <= mf3_pkg::COLS_REG_BITS'(1500);
      img_rows_q <= mf3_pkg::ROWS_REG_BITS'(1024);
      col_q      <= '0;
      row_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      out_v_q    <= 1'b0;
      skid_v_q   <= 1'b0;
    end else begin
      img_cols_q <= img_cols_d;
      img_rows_q <= img_rows_d;
      col_q      <= col_d;
      row_q      <= row_d;
      if (pipe_en) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q.col, out_q.row, out_q.median};
  assign m_axis_tlast  = out_q.last;

endmodule
